// ===== rtl/core/rvig_pkg.sv =====
package rvig_pkg;

  // sample format
  localparam int SAMPLE_BITS = 16;
  localparam int LANES       = 4;
  localparam int NUM_CH      = 4;
  localparam int CHAN_W      = 16;

  // fixed-point geometry
  localparam int POS_W     = 13;
  localparam int CPCT_W    = 15;
  localparam int PCT_W     = 16;
  localparam int DIM_W     = 14;
  localparam int CH_CNT_W  = 3;
  localparam int PCT_ONE   = 25600;
  localparam int PCT_ONE_W = 15;
  localparam int PX_W      = POS_W + PCT_ONE_W;       // pixel position, 1/25600 px
  localparam int DIFF_W    = DIM_W + CPCT_W;          // center and distance
  localparam int SQ_W      = 2 * DIFF_W + 2;          // sum of squares, even width
  localparam int D_W       = SQ_W / 2;                // root width
  localparam int REM_W     = D_W + 3;
  localparam int SQRT_STEPS = D_W;
  localparam int RH_W      = PCT_W + DIM_W;
  localparam int DEN_W     = RH_W + PCT_ONE_W;
  localparam int V_W       = 16;
  localparam int V_FRAC    = 12;
  localparam int PROD_W    = PCT_W + D_W;
  localparam int DIV_STEPS = V_W;
  localparam int RINIT_W   = PROD_W + V_FRAC - V_W;
  localparam int DREM_W    = DEN_W + 1;

  // stage counts
  localparam int WEIGHT_LAT = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int LANE_LAT   = 5;
  localparam int PIPE_LAT   = WEIGHT_LAT + LANE_LAT;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_STRENGTH = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_CHANNELS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CPCT_W-1:0] center_x_pct;
    logic [CPCT_W-1:0] center_y_pct;
    logic [PCT_W-1:0]  radius_pct;
    logic [PCT_W-1:0]  strength_pct;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
  } geom_cfg_t;

endpackage

// ===== rtl/core/rvig_weight.sv =====
// Vignette weight v (Q4.12) from pixel position: distance, square root, divide.
module rvig_weight (
  input  logic                           clk,
  input  logic                           en,
  input  rvig_pkg::geom_cfg_t            cfg,
  input  logic [rvig_pkg::POS_W-1:0]     pos_x,
  input  logic [rvig_pkg::POS_W-1:0]     pos_y,
  output logic [rvig_pkg::V_W-1:0]       v
);

  localparam int DIFF_W = rvig_pkg::DIFF_W;
  localparam int SQ_W   = rvig_pkg::SQ_W;
  localparam int D_W    = rvig_pkg::D_W;
  localparam int REM_W  = rvig_pkg::REM_W;
  localparam int NS     = rvig_pkg::SQRT_STEPS;
  localparam int ND     = rvig_pkg::DIV_STEPS;
  localparam int DEN_W  = rvig_pkg::DEN_W;
  localparam int DREM_W = rvig_pkg::DREM_W;
  localparam int PROD_W = rvig_pkg::PROD_W;
  localparam int V_W    = rvig_pkg::V_W;
  localparam int LOW_W  = rvig_pkg::V_W;
  localparam int SH     = rvig_pkg::V_W - rvig_pkg::V_FRAC;

  // divisor: config is static while pixels flow, so this runs free
  logic [rvig_pkg::RH_W-1:0] rh;
  logic [DEN_W-1:0]          den;

  always_ff @(posedge clk) begin
    rh  <= cfg.radius_pct * cfg.image_height;
    den <= DEN_W'(rh) * DEN_W'(rvig_pkg::PCT_ONE);
  end

  // positions and center
  logic [DIFF_W-1:0] px, py, cx, cy;
  logic [DIFF_W-1:0] dx, dy;
  logic [2*DIFF_W-1:0] dx2, dy2;
  logic [SQ_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= DIFF_W'(pos_x) * DIFF_W'(rvig_pkg::PCT_ONE);
      py  <= DIFF_W'(pos_y) * DIFF_W'(rvig_pkg::PCT_ONE);
      cx  <= DIFF_W'(cfg.image_width) * DIFF_W'(cfg.center_x_pct);
      cy  <= DIFF_W'(cfg.image_height) * DIFF_W'(cfg.center_y_pct);
      dx  <= (px >= cx) ? px - cx : cx - px;
      dy  <= (py >= cy) ? py - cy : cy - py;
      dx2 <= dx * dx;
      dy2 <= dy * dy;
      sq  <= SQ_W'(dx2) + SQ_W'(dy2);
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0]  rad_s  [NS+1];
  logic [REM_W-1:0] rem_s  [NS+1];
  logic [D_W-1:0]   root_s [NS+1];

  assign rad_s[0]  = sq;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [REM_W-1:0] cur, trial;
    assign cur   = {rem_s[k][REM_W-3:0], rad_s[k][SQ_W-1 -: 2]};
    assign trial = REM_W'({root_s[k], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1] <= rad_s[k] << 2;
        if (cur >= trial) begin
          rem_s[k+1]  <= cur - trial;
          root_s[k+1] <= {root_s[k][D_W-2:0], 1'b1};
        end else begin
          rem_s[k+1]  <= cur;
          root_s[k+1] <= {root_s[k][D_W-2:0], 1'b0};
        end
      end
    end
  end

  logic [PROD_W-1:0] prod;
  always_ff @(posedge clk) begin
    if (en) prod <= PROD_W'(cfg.strength_pct) * PROD_W'(root_s[NS]);
  end

  // restoring divide of prod*4096 by den, saturating at V_W bits
  logic [DREM_W-1:0] drem [ND+1];
  logic [LOW_W-1:0]  dlow [ND+1];
  logic [V_W-1:0]    dq   [ND+1];
  logic              dsat [ND+1];

  assign drem[0] = DREM_W'(prod >> SH);
  assign dlow[0] = {prod[SH-1:0], {rvig_pkg::V_FRAC{1'b0}}};
  assign dq[0]   = '0;
  assign dsat[0] = DREM_W'(prod >> SH) >= DREM_W'(den);

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [DREM_W-1:0] cur;
    assign cur = {drem[j][DREM_W-2:0], dlow[j][LOW_W-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        dlow[j+1] <= dlow[j] << 1;
        dsat[j+1] <= dsat[j];
        if (cur >= DREM_W'(den)) begin
          drem[j+1] <= cur - DREM_W'(den);
          dq[j+1]   <= {dq[j][V_W-2:0], 1'b1};
        end else begin
          drem[j+1] <= cur;
          dq[j+1]   <= {dq[j][V_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) v <= dsat[ND] ? '1 : dq[ND];
  end

endmodule

// ===== rtl/core/rvig_lane.sv =====
// One channel: ceil(s * (4096M - v(M-s)) / 4096M), zero when the weight wins.
module rvig_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rvig_pkg::V_W-1:0]          v,
  input  logic [rvig_pkg::SAMPLE_BITS-1:0]  s,
  output logic [rvig_pkg::SAMPLE_BITS-1:0]  q
);

  localparam int SB    = rvig_pkg::SAMPLE_BITS;
  localparam int VF    = rvig_pkg::V_FRAC;
  localparam int T_W   = rvig_pkg::V_W + SB;
  localparam int NUM_W = SB + VF;
  localparam int B_W   = SB + NUM_W;
  localparam int C_W   = 2 * SB + 1;
  localparam logic [SB-1:0]    M    = '1;
  localparam logic [NUM_W-1:0] FULL = {M, {VF{1'b0}}};
  localparam logic [B_W:0]     BIAS = (B_W+1)'({M - SB'(1), {VF{1'b1}}});

  logic [T_W-1:0]   t;
  logic [SB-1:0]    s_a, s_b;
  logic [NUM_W-1:0] num;
  logic             pos_b, pos_c, pos_d;
  logic [B_W-1:0]   b;
  logic [C_W-1:0]   c;

  // corrections of c / M via folding (M = 2^SB - 1)
  logic [SB:0]   q0, q1, q2;
  logic [SB+1:0] r0, r1;
  logic [B_W:0]  bsum;

  assign bsum = (B_W+1)'(b) + BIAS;

  always_comb begin
    q0 = c[C_W-1:SB];
    r0 = (SB+2)'(c[SB-1:0]) + (SB+2)'(q0);
    if (r0 >= (SB+2)'(M)) begin
      r1 = r0 - (SB+2)'(M);
      q1 = q0 + 1'b1;
    end else begin
      r1 = r0;
      q1 = q0;
    end
    if (r1 >= (SB+2)'(M)) begin
      q2 = q1 + 1'b1;
    end else begin
      q2 = q1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t     <= v * (M - s);
      s_a   <= s;
      pos_b <= t < T_W'(FULL);
      num   <= FULL - NUM_W'(t);
      s_b   <= s_a;
      b     <= B_W'(s_b) * B_W'(num);
      pos_c <= pos_b;
      c     <= C_W'(bsum >> VF);
      pos_d <= pos_c;
      if (!pos_d)                   q <= '0;
      else if (q2 > (SB+1)'(M))     q <= M;
      else                          q <= q2[SB-1:0];
    end
  end

endmodule

// ===== rtl/core/radial_vignette_pixel_top.sv =====
// Radial vignette, one pixel per beat. Each input beat carries a pixel's
// column, row and four 16-bit samples; each output beat carries the four
// darkened samples, in order, one output beat per input beat. A new pixel is
// accepted every clock while the output side takes beats; the latency is
// set by the 30-stage square root and the 16-stage divider that form the
// weight, plus five stages in each channel lane and the output register.
// A stalled output stops the whole pipeline and drops s_tready in the same
// cycle. Configuration writes (cfg_index 0..6 in register-list order, other
// indexes ignored) are always taken and must only happen while no pixel is
// in flight. Channels at or above channels_used come out as zero.
module radial_vignette_pixel_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x[12:0], pos_y[25:13], chan0_in[41:26], chan1_in[57:42],
  // chan2_in[73:58], chan3_in[89:74], zero pad[95:90]
  input  logic [rvig_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // chan0_out[15:0], chan1_out[31:16], chan2_out[47:32], chan3_out[63:48]
  output logic [rvig_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rvig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rvig_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB   = rvig_pkg::SAMPLE_BITS;
  localparam int CW   = rvig_pkg::CHAN_W;
  localparam int NCH  = rvig_pkg::NUM_CH;
  localparam int WL   = rvig_pkg::WEIGHT_LAT;
  localparam int PL   = rvig_pkg::PIPE_LAT;
  localparam int PW   = rvig_pkg::POS_W;
  localparam int CUW  = rvig_pkg::CH_CNT_W;

  // ---------------- configuration registers ----------------
  rvig_pkg::geom_cfg_t geom;
  logic [CUW-1:0]      channels_used;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.center_x_pct <= rvig_pkg::CPCT_W'(12800);
      geom.center_y_pct <= rvig_pkg::CPCT_W'(12800);
      geom.radius_pct   <= rvig_pkg::PCT_W'(25600);
      geom.strength_pct <= rvig_pkg::PCT_W'(12800);
      geom.image_width  <= rvig_pkg::DIM_W'(1920);
      geom.image_height <= rvig_pkg::DIM_W'(1080);
      channels_used     <= CUW'(3);
    end else if (cfg_valid) begin
      case (rvig_pkg::cfg_reg_t'(cfg_index))
        rvig_pkg::REG_CENTER_X: geom.center_x_pct <= cfg_data[rvig_pkg::CPCT_W-1:0];
        rvig_pkg::REG_CENTER_Y: geom.center_y_pct <= cfg_data[rvig_pkg::CPCT_W-1:0];
        rvig_pkg::REG_RADIUS:   geom.radius_pct   <= cfg_data;
        rvig_pkg::REG_STRENGTH: geom.strength_pct <= cfg_data;
        rvig_pkg::REG_WIDTH:    geom.image_width  <= cfg_data[rvig_pkg::DIM_W-1:0];
        rvig_pkg::REG_HEIGHT:   geom.image_height <= cfg_data[rvig_pkg::DIM_W-1:0];
        rvig_pkg::REG_CHANNELS: channels_used     <= cfg_data[CUW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Whole pipe advances when the output register is free or being drained.
  logic en;
  logic vld [PL];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PL; k++) vld[k] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < PL; k++) vld[k] <= vld[k-1];
      m_tvalid <= vld[PL-1];
    end
  end

  // ---------------- weight ----------------
  logic [rvig_pkg::V_W-1:0] v;

  rvig_weight u_weight (
    .clk   (clk),
    .en    (en),
    .cfg   (geom),
    .pos_x (s_tdata[PW-1:0]),
    .pos_y (s_tdata[2*PW-1:PW]),
    .v     (v)
  );

  // samples ride alongside the weight pipeline
  logic [SB-1:0] smp [WL][NCH];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCH; i++) begin
        smp[0][i] <= s_tdata[2*PW + i*CW +: SB];
        for (int k = 1; k < WL; k++) smp[k][i] <= smp[k-1][i];
      end
    end
  end

  // ---------------- lanes and merge ----------------
  logic [SB-1:0] lane_q [NCH];
  logic [CUW-1:0] act;

  assign act = (channels_used < CUW'(rvig_pkg::LANES)) ? channels_used
                                                       : CUW'(rvig_pkg::LANES);

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    if (i < rvig_pkg::LANES) begin : g_on
      rvig_lane u_lane (
        .clk (clk),
        .en  (en),
        .v   (v),
        .s   (smp[WL-1][i]),
        .q   (lane_q[i])
      );
    end else begin : g_off
      assign lane_q[i] = '0;
    end
  end

  // merge: unused channels forced to zero in the output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCH; i++) begin
        m_tdata[i*CW +: CW] <= (CUW'(i) < act) ? CW'(lane_q[i]) : '0;
      end
    end
  end

  // ---------------- checks ----------------
  a_zero_lanes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && act == '0 && $past(en) && $past(act) == '0 |-> m_tdata == '0)
    else $error("output data nonzero with no channels in use");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  a_cfg_ch: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == rvig_pkg::REG_CHANNELS |=>
      channels_used == $past(cfg_data[CUW-1:0]))
    else $error("channels_used write lost");

endmodule
